### src/json_string_escape_utf8_repair_defines.svh
// Assertion macros shared by the string escaper RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef JSON_STRING_ESCAPE_UTF8_REPAIR_DEFINES_SVH
`define JSON_STRING_ESCAPE_UTF8_REPAIR_DEFINES_SVH
`ifndef SYNTHESIS
`define JSEU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jseu assertion failed");
`define JSEU_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("jseu assertion failed");
`else
`define JSEU_ASSERT(label, clk, rst_n, prop)
`define JSEU_NEVER(label, clk, rst_n, cond)
`endif
`endif

### src/jseu_pkg.sv
// Types, constants and byte-class functions for the JSON string escaper.
// No dependencies; used by every module of the block.
package jseu_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    typedef enum logic [1:0] {
        KIND_ASCII = 2'd0,
        KIND_RAW   = 2'd1,
        KIND_REPL  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_unit;

    typedef struct packed {
        t_unit [3:0] units;
        logic [1:0]  last_unit;
        logic        str_end;
    } t_cmd;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b >= 8'hC2 && b <= 8'hDF) len = 3'd2;
        else if (b >= 8'hE0 && b <= 8'hEF) len = 3'd3;
        else if (b >= 8'hF0 && b <= 8'hF4) len = 3'd4;
        else len = 3'd0;
        return len;
    endfunction

    function automatic logic follower_ok(input logic [7:0] lead, input logic [1:0] pos,
                                         input logic [7:0] b);
        logic ok;
        ok = (b & 8'hC0) == 8'h80;
        if (pos == 2'd1) begin
            if (lead == 8'hE0) ok = b >= 8'hA0 && b <= 8'hBF;
            else if (lead == 8'hED) ok = b >= 8'h80 && b <= 8'h9F;
            else if (lead == 8'hF0) ok = b >= 8'h90 && b <= 8'hBF;
            else if (lead == 8'hF4) ok = b >= 8'h80 && b <= 8'h8F;
        end
        return ok;
    endfunction

    // Letter of a two-character escape, zero if the byte has none.
    function automatic logic [7:0] short_esc(input logic [7:0] b);
        logic [7:0] c;
        unique case (b)
            CH_QUOTE:  c = CH_QUOTE;
            CH_BSLASH: c = CH_BSLASH;
            8'h08:     c = CH_B;
            8'h0C:     c = CH_F;
            8'h0A:     c = CH_N;
            8'h0D:     c = CH_R;
            8'h09:     c = CH_T;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) c = {4'h3, d};
        else c = 8'h57 + {4'h0, d};
        return c;
    endfunction

    function automatic logic [2:0] unit_len(input t_unit u);
        logic [2:0] len;
        unique case (u.kind)
            KIND_RAW:  len = 3'd1;
            KIND_REPL: len = 3'd6;
            KIND_ASCII: begin
                if (short_esc(u.data) != 8'h00) len = 3'd2;
                else if (u.data < 8'h20) len = 3'd6;
                else len = 3'd1;
            end
            default:   len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] unit_char(input t_unit u, input logic [2:0] c);
        logic [7:0] ch;
        logic [7:0] esc;
        esc = short_esc(u.data);
        ch  = u.data;
        unique case (u.kind)
            KIND_RAW: ch = u.data;
            KIND_REPL: begin
                unique case (c)
                    3'd0:    ch = CH_BSLASH;
                    3'd1:    ch = CH_U;
                    3'd5:    ch = CH_D;
                    default: ch = CH_F;
                endcase
            end
            KIND_ASCII: begin
                if (esc != 8'h00) begin
                    ch = (c == 3'd0) ? CH_BSLASH : esc;
                end else if (u.data < 8'h20) begin
                    unique case (c)
                        3'd0:    ch = CH_BSLASH;
                        3'd1:    ch = CH_U;
                        3'd4:    ch = hex_char(u.data[7:4]);
                        3'd5:    ch = hex_char(u.data[3:0]);
                        default: ch = CH_ZERO;
                    endcase
                end
            end
            default: ch = u.data;
        endcase
        return ch;
    endfunction

endpackage

### src/jseu_front.sv
// Front end: takes input bytes, tracks the held UTF-8 prefix and builds commands.
// Depends on jseu_pkg and json_string_escape_utf8_repair_defines.svh.
`include "json_string_escape_utf8_repair_defines.svh"
module jseu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_string_end,
    output logic            o_cmd_push,
    output jseu_pkg::t_cmd  o_cmd
);
    import jseu_pkg::*;

    logic [7:0] r_held [3];
    logic [1:0] r_held_count, n_held_count;
    logic [2:0] r_seq_len, n_seq_len;

    logic [2:0] b_len;
    logic       ok;
    logic       complete;
    logic       cont_case;
    logic       hold_fresh;
    logic       hold_extend;
    logic       b_has_unit;
    t_kind      b_kind;
    t_kind      prefix_kind;
    logic [2:0] unit_count;

    always_comb begin
        b_len       = lead_length(i_data_byte);
        ok          = follower_ok(r_held[0], r_held_count, i_data_byte);
        complete    = ({1'b0, r_held_count} + 3'd1) == r_seq_len;
        cont_case   = (r_held_count != 2'd0) && ok;
        hold_fresh  = 1'b0;
        hold_extend = 1'b0;
        b_has_unit  = 1'b1;
        b_kind      = KIND_ASCII;
        prefix_kind = KIND_REPL;
        if (cont_case) begin
            if (complete) begin
                b_kind      = KIND_RAW;
                prefix_kind = KIND_RAW;
            end else if (i_string_end) begin
                b_kind = KIND_REPL;
            end else begin
                hold_extend = 1'b1;
                b_has_unit  = 1'b0;
            end
        end else begin
            if (i_data_byte < 8'h80) begin
                b_kind = KIND_ASCII;
            end else if (b_len == 3'd0 || i_string_end) begin
                b_kind = KIND_REPL;
            end else begin
                hold_fresh = 1'b1;
                b_has_unit = 1'b0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_cmd.units[k].kind = b_kind;
            o_cmd.units[k].data = i_data_byte;
        end
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < r_held_count) begin
                o_cmd.units[k].kind = prefix_kind;
                o_cmd.units[k].data = r_held[k];
            end
        end
        // A byte that only extends the held prefix emits nothing yet.
        unit_count      = hold_extend ? 3'd0
                                      : {1'b0, r_held_count} + {2'b00, b_has_unit};
        o_cmd.last_unit = 2'(unit_count - 3'd1);
        o_cmd.str_end   = i_string_end;
        o_cmd_push      = i_accept && (unit_count != 3'd0);
    end

    always_comb begin
        n_held_count = 2'd0;
        n_seq_len    = 3'd0;
        if (hold_extend) begin
            n_held_count = r_held_count + 2'd1;
            n_seq_len    = r_seq_len;
        end else if (hold_fresh) begin
            n_held_count = 2'd1;
            n_seq_len    = b_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
            r_seq_len    <= 3'd0;
        end else if (i_accept) begin
            r_held_count <= n_held_count;
            r_seq_len    <= n_seq_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (hold_extend) begin
                r_held[r_held_count] <= i_data_byte;
            end else if (hold_fresh) begin
                r_held[0] <= i_data_byte;
            end
        end
    end

    `JSEU_ASSERT(a_held_len_pair, i_clk, i_rst_n, (r_held_count == 2'd0) == (r_seq_len == 3'd0))
    `JSEU_ASSERT(a_held_short, i_clk, i_rst_n, r_held_count != 2'd0 |-> r_seq_len > 3'(r_held_count))
    `JSEU_ASSERT(a_end_flushes, i_clk, i_rst_n, i_accept && i_string_end |=> r_held_count == 2'd0)

endmodule

### src/jseu_queue.sv
// Short command queue between the front end and the byte expander.
// Depends on jseu_pkg.
module jseu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jseu_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output jseu_pkg::t_cmd  o_cmd
);
    import jseu_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        unique case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push_ok) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop_ok) r_rd_ptr <= r_rd_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wr_ptr] <= i_cmd;
    end

endmodule

### src/jseu_back.sv
// Back end: expands queued commands into escaped bytes into the output register, one
// per cycle while it is empty or popped. Depends on jseu_pkg and the assertion macro header.
`include "json_string_escape_utf8_repair_defines.svh"
module jseu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  jseu_pkg::t_cmd  i_cmd,
    output logic            o_q_pop,
    output logic            empty,
    input  logic            pop,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_string_done
);
    import jseu_pkg::*;

    logic [1:0] r_unit, n_unit;
    logic [2:0] r_char, n_char;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic       r_odone;

    t_unit      cur;
    logic [2:0] ulen;
    logic       emit;
    logic       last_char;
    logic       last_unit;

    always_comb begin
        cur       = i_cmd.units[r_unit];
        ulen      = unit_len(cur);
        emit      = i_q_valid && (!r_ovalid || pop);
        last_char = r_char == (ulen - 3'd1);
        last_unit = r_unit == i_cmd.last_unit;
        o_q_pop   = emit && last_char && last_unit;
        n_unit    = r_unit;
        n_char    = r_char;
        if (emit) begin
            if (!last_char) begin
                n_char = r_char + 3'd1;
            end else begin
                n_char = 3'd0;
                n_unit = last_unit ? 2'd0 : r_unit + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit   <= 2'd0;
            r_char   <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_unit <= n_unit;
            r_char <= n_char;
            if (emit) r_ovalid <= 1'b1;
            else if (pop) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte <= unit_char(cur, r_char);
            r_olast <= last_char && last_unit;
            r_odone <= last_char && last_unit && i_cmd.str_end;
        end
    end

    assign empty         = !r_ovalid;
    assign o_out_byte    = r_obyte;
    assign o_run_last    = r_olast;
    assign o_string_done = r_odone;

    `JSEU_ASSERT(a_unit_in_cmd, i_clk, i_rst_n, (i_q_valid |-> (r_unit <= i_cmd.last_unit)))
    `JSEU_ASSERT(a_char_in_unit, i_clk, i_rst_n, (i_q_valid |-> (r_char < ulen)))
    `JSEU_ASSERT(a_idle_at_start, i_clk, i_rst_n, (!i_q_valid |-> (r_unit == 2'd0 && r_char == 3'd0)))

endmodule

### src/json_string_escape_utf8_repair.sv
// Channel   Handshake            Beat
// input     push / full          i_data_byte, i_string_end
// result    empty / pop          o_out_byte, o_run_last, o_string_done
//
// The back end writes one escaped byte per cycle into the output register while a
// command is queued and the register is empty or popped. Each unit expands to 1, 2 or
// 6 bytes in the back end, up to 24 for a broken 4-byte sequence.
// Input beats are taken every cycle while the 4-entry command queue has room.
// Synchronous active-low reset clears the held-byte count, queue and output valid flag.
// Top level of the JSON string escaper; depends on jseu_pkg, jseu_front,
// jseu_queue and jseu_back.
module json_string_escape_utf8_repair (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_string_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_string_done
);
    import jseu_pkg::*;

    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    logic q_valid;
    logic q_pop;
    t_cmd cmd_head;

    assign accept = push && !full;

    jseu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_string_end (i_string_end),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    jseu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (cmd_head)
    );

    jseu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (cmd_head),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

endmodule
